@@ rtl/pretrigger_event_capture_top_defines.svh @@
// assertion macros for the pretrigger event capture block
// expects clk_i and rst_ni in the scope of each use
`ifndef PRETRIGGER_EVENT_CAPTURE_TOP_DEFINES_SVH
`define PRETRIGGER_EVENT_CAPTURE_TOP_DEFINES_SVH

// clocked assertion, off while reset is held
`define PEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same check, also evaluated during reset
`define PEC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/pec_pkg.sv @@
// shared types and constants of the pretrigger event capture block
// no dependencies
package pec_pkg;

  localparam int unsigned PRE_SAMPLES_DEF = 5;
  localparam int unsigned SAMPLE_W        = 16;
  localparam int unsigned STAMP_W         = 32;
  localparam int unsigned KIND_W          = 2;
  localparam int unsigned POST_W          = 4;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 16;

  localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POST_COUNT = 2'd1;

  localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RST  = 16'sd3000;
  localparam logic [POST_W-1:0]          POST_COUNT_RST = 4'd5;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

endpackage

@@ rtl/pec_cell.sv @@
// one cell of the pre-trigger sample chain
// depends on pec_pkg
module pec_cell (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [pec_pkg::SAMPLE_W-1:0] data_i,
  output logic signed [pec_pkg::SAMPLE_W-1:0] data_o
);

  logic signed [pec_pkg::SAMPLE_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

@@ rtl/pretrigger_event_capture_top.sv @@
// Pretrigger event capture, top level.
// Depends on pec_pkg, pec_cell and pretrigger_event_capture_top_defines.svh.
//
// Input channel (in_valid_i/in_ready_o) takes one beat of sample and time stamp.
// Output channel (out_valid_o/out_ready_i) gives beats of kind, value, stamp, last.
// A chain of PRE_SAMPLES cells holds the newest samples, oldest at cell 0.
// A beat that crosses threshold while armed, filling the chain or with it full,
// yields a header beat first; then the chain rotates one cell a cycle while the
// output is free and the PRE_SAMPLES buffered samples leave oldest first. A beat
// inside an open record yields one beat (sample or end marker), others yield none.
// Results appear the cycle after accept. The output register is single; while it
// waits for out_ready_i the block takes no new input and holds the rotation. Reset
// clears fill count, flags and the output valid flag; the sample cells are not
// reset and are never read before PRE_SAMPLES beats have been written.
// Configuration writes are registered before they take effect.
module pretrigger_event_capture_top #(
  parameter int unsigned PRE_SAMPLES = pec_pkg::PRE_SAMPLES_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [pec_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [pec_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [pec_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic [pec_pkg::STAMP_W-1:0]           time_stamp_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [pec_pkg::KIND_W-1:0]            kind_o,
  output logic signed [pec_pkg::SAMPLE_W-1:0]   value_o,
  output logic [pec_pkg::STAMP_W-1:0]           stamp_o,
  output logic                                  last_o
);

`include "pretrigger_event_capture_top_defines.svh"

  localparam int unsigned CNT_W = $clog2(PRE_SAMPLES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PRE_SAMPLES);
  localparam logic [CNT_W-1:0] CNT_ALMOST = CNT_W'(PRE_SAMPLES - 1);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // configuration
  logic signed [pec_pkg::SAMPLE_W-1:0] threshold_q;
  logic [pec_pkg::POST_W-1:0]          post_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= pec_pkg::THRESHOLD_RST;
      post_count_q <= pec_pkg::POST_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pec_pkg::CFG_THRESHOLD:  threshold_q  <= cfg_data_i;
        pec_pkg::CFG_POST_COUNT: post_count_q <= cfg_data_i[pec_pkg::POST_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  pec_pkg::state_e            state_q, state_d;
  logic [CNT_W-1:0]           fill_q, fill_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       triggered_q, triggered_d;
  logic                       capturing_q, capturing_d;
  logic [pec_pkg::POST_W-1:0] remaining_q, remaining_d;

  logic                                out_valid_q, out_valid_d;
  logic [pec_pkg::KIND_W-1:0]          kind_q, kind_d;
  logic signed [pec_pkg::SAMPLE_W-1:0] value_q, value_d;
  logic [pec_pkg::STAMP_W-1:0]         stamp_q, stamp_d;
  logic                                last_q, last_d;

  logic out_free;
  logic accept;
  logic rotate;
  logic at_thr;

  logic signed [pec_pkg::SAMPLE_W-1:0] cell_d [PRE_SAMPLES];
  logic signed [pec_pkg::SAMPLE_W-1:0] cell_q [PRE_SAMPLES];

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == pec_pkg::ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign rotate     = (state_q == pec_pkg::ST_EMIT) && out_free;
  assign at_thr     = sample_i >= threshold_q;

  // sample chain: shift in on accept, rotate oldest to newest while draining
  for (genvar g = 0; g < PRE_SAMPLES; g++) begin : g_chain
    if (g == PRE_SAMPLES - 1) begin : g_tail
      assign cell_d[g] = rotate ? cell_q[0] : sample_i;
    end else begin : g_body
      assign cell_d[g] = cell_q[g+1];
    end
    pec_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (accept || rotate),
      .data_i (cell_d[g]),
      .data_o (cell_q[g])
    );
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    triggered_d = triggered_q;
    capturing_d = capturing_q;
    remaining_d = remaining_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    value_d     = value_q;
    stamp_d     = stamp_q;
    last_d      = last_q;

    unique case (state_q)
      pec_pkg::ST_IDLE: begin
        if (accept) begin
          if (fill_q != CNT_FULL) begin
            fill_d = fill_q + CNT_ONE;
          end
          if (!capturing_q) begin
            if (at_thr && !triggered_q) begin
              triggered_d = 1'b1;
              if (fill_q >= CNT_ALMOST) begin
                capturing_d = 1'b1;
                remaining_d = post_count_q;
                out_valid_d = 1'b1;
                kind_d      = pec_pkg::KIND_HEADER;
                value_d     = '0;
                stamp_d     = time_stamp_i;
                last_d      = 1'b0;
                cnt_d       = CNT_FULL;
                state_d     = pec_pkg::ST_EMIT;
              end
            end else if (!at_thr && triggered_q) begin
              triggered_d = 1'b0;
            end
          end else if (remaining_q != '0) begin
            remaining_d = remaining_q - pec_pkg::POST_W'(1);
            out_valid_d = 1'b1;
            kind_d      = pec_pkg::KIND_SAMPLE;
            value_d     = sample_i;
            stamp_d     = '0;
            last_d      = 1'b1;
          end else begin
            capturing_d = 1'b0;
            out_valid_d = 1'b1;
            kind_d      = pec_pkg::KIND_END;
            value_d     = '0;
            stamp_d     = '0;
            last_d      = 1'b1;
          end
        end
      end
      pec_pkg::ST_EMIT: begin
        if (rotate) begin
          out_valid_d = 1'b1;
          kind_d      = pec_pkg::KIND_SAMPLE;
          value_d     = cell_q[0];
          stamp_d     = '0;
          last_d      = (cnt_q == CNT_ONE);
          cnt_d       = cnt_q - CNT_ONE;
          if (cnt_q == CNT_ONE) begin
            state_d = pec_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = pec_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pec_pkg::ST_IDLE;
      fill_q      <= '0;
      cnt_q       <= '0;
      triggered_q <= 1'b0;
      capturing_q <= 1'b0;
      remaining_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      triggered_q <= triggered_d;
      capturing_q <= capturing_d;
      remaining_q <= remaining_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    value_q <= value_d;
    stamp_q <= stamp_d;
    last_q  <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign value_o     = value_q;
  assign stamp_o     = stamp_q;
  assign last_o      = last_q;

  `PEC_ASSERT(a_emit_blocks_input, (state_q == pec_pkg::ST_EMIT) |-> !in_ready_o, "input taken while draining")
  `PEC_ASSERT(a_emit_cnt_live, (state_q == pec_pkg::ST_EMIT) |-> (cnt_q != '0), "drain counter empty while draining")
  `PEC_ASSERT(a_header_open, (out_valid_q && kind_q == pec_pkg::KIND_HEADER) |-> (capturing_q && triggered_q), "header without open record")
  `PEC_ASSERT_ALWAYS(a_fill_bound, !rst_ni || (fill_q <= CNT_FULL), "fill count beyond chain length")

endmodule
